// ===== rtl/core/rsc_pkg.sv =====
// Shared types, codes and constants of the integer core with DRAM row timing.
package rsc_pkg;

	localparam int DATA_ADDR_BITS_DEF = 19;
	localparam int PROGRAM_WORDS_DEF  = 131072;
	localparam int PC_BITS            = 17;
	localparam int ROW_SHIFT          = 10;
	localparam int APB_ADDR_BITS      = 3;
	localparam int QUEUE_DEPTH        = 2;
	localparam int QPTR_BITS          = $clog2(QUEUE_DEPTH);

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_SLT  = 4'd3,
		OP_ADDI = 4'd4,
		OP_BEQ  = 4'd5,
		OP_BNE  = 4'd6,
		OP_J    = 4'd7,
		OP_LW   = 4'd8,
		OP_SW   = 4'd9
	} opcode_t;

	typedef enum logic [2:0] {
		CL_ALU,
		CL_BEQ,
		CL_BNE,
		CL_JUMP,
		CL_LOAD,
		CL_STORE,
		CL_NOP
	} op_class_t;

	typedef enum logic [1:0] {
		AL_ADD,
		AL_SUB,
		AL_MUL,
		AL_SLT
	} alu_op_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_READ,
		BK_EXEC,
		BK_LOAD
	} bk_state_t;

	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_FIRST = 2'd1;
	localparam logic [1:0] EV_SWAP  = 2'd2;

	localparam logic ST_OK       = 1'b0;
	localparam logic ST_BAD_ADDR = 1'b1;

	localparam logic CFG_ROW_DELAY = 1'b0;
	localparam logic CFG_COL_DELAY = 1'b1;

	typedef struct packed {
		op_class_t          op_class;
		alu_op_t            alu_op;
		logic [4:0]         dest;
		logic [4:0]         src;
		logic [4:0]         second;
		logic               use_imm;
		logic [31:0]        imm;
		logic [PC_BITS-1:0] target;
	} qentry_t;

	typedef struct packed {
		logic [7:0] row_delay;
		logic [7:0] col_delay;
	} cfg_t;

	typedef struct packed {
		logic [PC_BITS-1:0] next_pc;
		logic               reg_written;
		logic [4:0]         written_reg;
		logic [31:0]        written_value;
		logic [9:0]         mem_latency;
		logic [1:0]         row_event;
		logic               status;
	} result_t;

endpackage

// ===== rtl/core/rsc_ifs.sv =====
// Handshake interfaces for the instruction and result channels.
interface rsc_in_if;
	logic               valid;
	logic               ready;
	logic [3:0]         opcode;
	logic [4:0]         dest_reg;
	logic [4:0]         src_reg;
	logic [4:0]         second_reg;
	logic               use_immediate;
	logic signed [17:0] immediate;
	logic [16:0]        branch_target;

	modport source(output valid, opcode, dest_reg, src_reg, second_reg, use_immediate,
		immediate, branch_target, input ready);
	modport sink(input valid, opcode, dest_reg, src_reg, second_reg, use_immediate,
		immediate, branch_target, output ready);
endinterface

interface rsc_out_if;
	logic               valid;
	logic               ready;
	logic [16:0]        next_pc;
	logic               reg_written;
	logic [4:0]         written_reg;
	logic signed [31:0] written_value;
	logic [9:0]         mem_latency;
	logic [1:0]         row_event;
	logic               status;

	modport source(output valid, next_pc, reg_written, written_reg, written_value,
		mem_latency, row_event, status, input ready);
	modport sink(input valid, next_pc, reg_written, written_reg, written_value,
		mem_latency, row_event, status, output ready);
endinterface

// ===== rtl/core/risc_subset_core_with_dram_row_timing.sv =====
// Top level of the integer core subset with DRAM row timing and an APB register port.
//
//  channel   direction  transaction / access
//  inst      in         one decoded instruction (valid/ready)
//  result    out        one execution result per instruction (valid/ready)
//  apb       in/out     row_delay at 0x0, col_delay at 0x4, pready always high
//
// The front end decodes and registers an instruction and then queues it.
// The back end steps each instruction through register read and execute, and a load also
// through a load step whose data comes from the synchronous data memory read port.
// After reset a pass writes zero into every one of the 2^(DATA_ADDR_BITS-2) data words
// (131072 at the default size); inst.ready stays low until it is done.
// The result register lets the back end read the next instruction while a result waits,
// but a result not yet taken stalls the back end; a full queue stalls the front end.
module risc_subset_core_with_dram_row_timing
	import rsc_pkg::*;
#(
	parameter int DATA_ADDR_BITS = DATA_ADDR_BITS_DEF,
	parameter int PROGRAM_WORDS  = PROGRAM_WORDS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	rsc_in_if.sink                   inst,
	rsc_out_if.source                result,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	cfg_t    cfg_q;
	logic    clearing;
	logic    full;
	logic    push;
	qentry_t entry;
	logic    pop;
	logic    head_valid;
	qentry_t head;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_delay <= 8'd10;
			cfg_q.col_delay <= 8'd2;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				CFG_ROW_DELAY: cfg_q.row_delay <= pwdata[7:0];
				CFG_COL_DELAY: cfg_q.col_delay <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			CFG_ROW_DELAY: prdata = {24'd0, cfg_q.row_delay};
			CFG_COL_DELAY: prdata = {24'd0, cfg_q.col_delay};
			default:       prdata = '0;
		endcase
	end

	rsc_front #(
		.PROGRAM_WORDS(PROGRAM_WORDS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.inst     (inst),
		.clearing (clearing),
		.full     (full),
		.push     (push),
		.entry    (entry)
	);

	rsc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.entry      (entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	rsc_back #(
		.DATA_ADDR_BITS(DATA_ADDR_BITS),
		.PROGRAM_WORDS (PROGRAM_WORDS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.clearing   (clearing),
		.result     (result)
	);

endmodule

// ===== rtl/core/rsc_front.sv =====
// Front end: accepts instructions, decodes them and reduces the branch target.
module rsc_front
	import rsc_pkg::*;
#(
	parameter int PROGRAM_WORDS = PROGRAM_WORDS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	rsc_in_if.sink       inst,
	input  logic         clearing,
	input  logic         full,
	output logic         push,
	output qentry_t      entry
);

	// Target modulo PROGRAM_WORDS by a reciprocal multiply: exact for all 17-bit targets.
	localparam int P_BITS     = $clog2(PROGRAM_WORDS);
	localparam int SHIFT      = PC_BITS + P_BITS;
	localparam longint unsigned RECIP =
		((64'd1 << SHIFT) + longint'(PROGRAM_WORDS) - 64'd1) / longint'(PROGRAM_WORDS);
	localparam int RECIP_BITS = PC_BITS + 2;
	localparam int PROD_BITS  = SHIFT + PC_BITS;
	localparam int QP_BITS    = PC_BITS + P_BITS + 1;

	logic                 valid_s1;
	qentry_t              entry_s1;
	logic [PROD_BITS-1:0] prod_s1;
	qentry_t              dec;
	logic                 accept;
	logic [PC_BITS-1:0]   quot;
	logic [QP_BITS-1:0]   qp;
	logic [QP_BITS-1:0]   rem;

	assign inst.ready = !clearing && (!valid_s1 || !full);
	assign accept     = inst.valid && inst.ready;
	assign push       = valid_s1 && !full;

	always_comb begin
		dec          = '0;
		dec.dest     = inst.dest_reg;
		dec.src      = inst.src_reg;
		dec.second   = inst.second_reg;
		dec.use_imm  = inst.use_immediate;
		dec.imm      = {{14{inst.immediate[17]}}, inst.immediate};
		dec.target   = inst.branch_target;
		dec.op_class = CL_NOP;
		dec.alu_op   = AL_ADD;
		case (inst.opcode)
			OP_ADD: begin
				dec.op_class = CL_ALU;
			end
			OP_SUB: begin
				dec.op_class = CL_ALU;
				dec.alu_op   = AL_SUB;
			end
			OP_MUL: begin
				dec.op_class = CL_ALU;
				dec.alu_op   = AL_MUL;
			end
			OP_SLT: begin
				dec.op_class = CL_ALU;
				dec.alu_op   = AL_SLT;
			end
			OP_ADDI: begin
				dec.op_class = CL_ALU;
				dec.use_imm  = 1'b1;
			end
			OP_BEQ:  dec.op_class = CL_BEQ;
			OP_BNE:  dec.op_class = CL_BNE;
			OP_J:    dec.op_class = CL_JUMP;
			OP_LW:   dec.op_class = CL_LOAD;
			OP_SW:   dec.op_class = CL_STORE;
			default: dec.op_class = CL_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1 <= dec;
			prod_s1  <= PROD_BITS'(inst.branch_target) * PROD_BITS'(RECIP_BITS'(RECIP));
		end
	end

	always_comb begin
		quot  = prod_s1[SHIFT +: PC_BITS];
		qp    = QP_BITS'(quot) * QP_BITS'(PROGRAM_WORDS);
		rem   = QP_BITS'(entry_s1.target) - qp;
		entry = entry_s1;
		entry.target = rem[PC_BITS-1:0];
	end

endmodule

// ===== rtl/core/rsc_queue.sv =====
// Short instruction queue between the front end and the back end.
module rsc_queue
	import rsc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  qentry_t entry,
	output logic    full,
	input  logic    pop,
	output logic    head_valid,
	output qentry_t head
);

	qentry_t              ent_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;

	assign full       = count_q == (QPTR_BITS+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= entry;
		end
	end

endmodule

// ===== rtl/core/rsc_back.sv =====
// Back end: register file, data memory, row timing, program counter and result register.
module rsc_back
	import rsc_pkg::*;
#(
	parameter int DATA_ADDR_BITS = DATA_ADDR_BITS_DEF,
	parameter int PROGRAM_WORDS  = PROGRAM_WORDS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     head_valid,
	input  qentry_t  head,
	output logic     pop,
	output logic     clearing,
	rsc_out_if.source result
);

	localparam int WORD_BITS = DATA_ADDR_BITS - 2;
	localparam int DM_WORDS  = 1 << WORD_BITS;
	localparam int ROW_BITS  = DATA_ADDR_BITS - ROW_SHIFT;

	bk_state_t state_q, state_d;

	qentry_t              instr_q;
	logic [WORD_BITS-1:0] clr_q;
	logic [PC_BITS-1:0]   pc_q;
	logic [ROW_BITS-1:0]  open_row_q;
	logic                 row_open_q;
	logic [9:0]           ld_lat_q;
	logic [1:0]           ld_evt_q;
	logic                 res_valid_q;
	result_t              res_q;

	// Register file with registered read ports; entries not yet written read as zero.
	logic [31:0] rf_mem [32];
	logic [31:0] rf_valid_q;
	logic [31:0] rd0_q;
	logic [31:0] rd1_q;
	logic        rf_re;
	logic [4:0]  rf_raddr1;
	logic        rf_we;
	logic [31:0] rf_wdata;

	logic [31:0]          dm_mem [DM_WORDS];
	logic [31:0]          dm_rdata_q;
	logic                 dm_we;
	logic [WORD_BITS-1:0] dm_waddr;
	logic [31:0]          dm_wdata;
	logic                 dm_re;

	logic                 can_out;
	logic [31:0]          op_b;
	logic [31:0]          alu_val;
	logic [31:0]          addr;
	logic                 bad;
	logic [ROW_BITS-1:0]  row;
	logic [WORD_BITS-1:0] word;
	logic [9:0]           lat;
	logic [1:0]           evt;
	logic [PC_BITS:0]     pc_n;
	logic [PC_BITS-1:0]   pc_inc;
	logic [PC_BITS-1:0]   ex_pc;
	logic                 ld_go;
	logic                 pc_we;
	logic                 row_we;
	logic                 res_load;
	result_t              res_d;

	assign can_out  = !res_valid_q || result.ready;
	assign clearing = state_q == BK_CLEAR;

	always_comb begin
		op_b = instr_q.use_imm ? instr_q.imm : rd1_q;
		case (instr_q.alu_op)
			AL_ADD:  alu_val = rd0_q + op_b;
			AL_SUB:  alu_val = rd0_q - op_b;
			AL_MUL:  alu_val = rd0_q * op_b;
			AL_SLT:  alu_val = {31'd0, $signed(rd0_q) < $signed(op_b)};
			default: alu_val = '0;
		endcase
	end

	always_comb begin
		addr = rd0_q + instr_q.imm;
		bad  = (addr[1:0] != 2'd0) || (addr[31:DATA_ADDR_BITS] != '0);
		row  = addr[DATA_ADDR_BITS-1:ROW_SHIFT];
		word = addr[DATA_ADDR_BITS-1:2];
		if (!row_open_q) begin
			lat = {2'd0, cfg.row_delay} + {2'd0, cfg.col_delay};
			evt = EV_FIRST;
		end else if (row != open_row_q) begin
			lat = {1'b0, cfg.row_delay, 1'b0} + {2'd0, cfg.col_delay};
			evt = EV_SWAP;
		end else begin
			lat = {2'd0, cfg.col_delay};
			evt = EV_NONE;
		end
	end

	always_comb begin
		pc_n   = {1'b0, pc_q} + 1'b1;
		pc_inc = (32'(pc_n) >= 32'(PROGRAM_WORDS)) ? PC_BITS'(32'(pc_n) - 32'(PROGRAM_WORDS))
			: pc_n[PC_BITS-1:0];
		case (instr_q.op_class)
			CL_BEQ:   ex_pc = (rd0_q == op_b) ? instr_q.target : pc_inc;
			CL_BNE:   ex_pc = (rd0_q != op_b) ? instr_q.target : pc_inc;
			CL_JUMP:  ex_pc = instr_q.target;
			CL_LOAD,
			CL_STORE: ex_pc = bad ? pc_q : pc_inc;
			default:  ex_pc = pc_inc;
		endcase
	end

	assign ld_go = (instr_q.op_class == CL_LOAD) && !bad;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_CLEAR: begin
				if (&clr_q) begin
					state_d = BK_READ;
				end
			end
			BK_READ: begin
				if (head_valid) begin
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				if (ld_go) begin
					state_d = BK_LOAD;
				end else if (can_out) begin
					state_d = BK_READ;
				end
			end
			BK_LOAD: begin
				if (can_out) begin
					state_d = BK_READ;
				end
			end
			default: state_d = BK_CLEAR;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		rf_re     = 1'b0;
		rf_raddr1 = (head.op_class == CL_STORE) ? head.dest : head.second;
		rf_we     = 1'b0;
		rf_wdata  = alu_val;
		dm_we     = 1'b0;
		dm_waddr  = word;
		dm_wdata  = rd1_q;
		dm_re     = 1'b0;
		pc_we     = 1'b0;
		row_we    = 1'b0;
		res_load  = 1'b0;
		res_d     = '0;
		res_d.next_pc = ex_pc;
		case (state_q)
			BK_CLEAR: begin
				dm_we    = 1'b1;
				dm_waddr = clr_q;
				dm_wdata = '0;
			end
			BK_READ: begin
				pop   = head_valid;
				rf_re = head_valid;
			end
			BK_EXEC: begin
				if (ld_go) begin
					dm_re  = 1'b1;
					row_we = 1'b1;
					pc_we  = 1'b1;
				end else if (can_out) begin
					res_load = 1'b1;
					pc_we    = 1'b1;
					case (instr_q.op_class)
						CL_ALU: begin
							if (instr_q.dest != 5'd0) begin
								rf_we               = 1'b1;
								res_d.reg_written   = 1'b1;
								res_d.written_reg   = instr_q.dest;
								res_d.written_value = alu_val;
							end
						end
						CL_LOAD: begin
							res_d.status = ST_BAD_ADDR;
						end
						CL_STORE: begin
							if (bad) begin
								res_d.status = ST_BAD_ADDR;
							end else begin
								dm_we               = 1'b1;
								row_we              = 1'b1;
								res_d.written_value = rd1_q;
								res_d.mem_latency   = lat;
								res_d.row_event     = evt;
							end
						end
						default: ;
					endcase
				end
			end
			BK_LOAD: begin
				res_d.next_pc     = pc_q;
				res_d.mem_latency = ld_lat_q;
				res_d.row_event   = ld_evt_q;
				rf_wdata          = dm_rdata_q;
				if (can_out) begin
					res_load = 1'b1;
					if (instr_q.dest != 5'd0) begin
						rf_we               = 1'b1;
						res_d.reg_written   = 1'b1;
						res_d.written_reg   = instr_q.dest;
						res_d.written_value = dm_rdata_q;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_q       <= '0;
			pc_q        <= '0;
			open_row_q  <= '0;
			row_open_q  <= 1'b0;
			rf_valid_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (pc_we) begin
				pc_q <= ex_pc;
			end
			if (row_we) begin
				open_row_q <= row;
				row_open_q <= 1'b1;
			end
			if (rf_we) begin
				rf_valid_q[instr_q.dest] <= 1'b1;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			instr_q <= head;
		end
		if (dm_re) begin
			ld_lat_q <= lat;
			ld_evt_q <= evt;
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_mem[instr_q.dest] <= rf_wdata;
		end
		if (rf_re) begin
			rd0_q <= (head.src == 5'd0 || !rf_valid_q[head.src]) ? '0 : rf_mem[head.src];
			rd1_q <= (rf_raddr1 == 5'd0 || !rf_valid_q[rf_raddr1]) ? '0 : rf_mem[rf_raddr1];
		end
	end

	always_ff @(posedge clk) begin
		if (dm_we) begin
			dm_mem[dm_waddr] <= dm_wdata;
		end
		if (dm_re) begin
			dm_rdata_q <= dm_mem[word];
		end
	end

	assign result.valid         = res_valid_q;
	assign result.next_pc       = res_q.next_pc;
	assign result.reg_written   = res_q.reg_written;
	assign result.written_reg   = res_q.written_reg;
	assign result.written_value = res_q.written_value;
	assign result.mem_latency   = res_q.mem_latency;
	assign result.row_event     = res_q.row_event;
	assign result.status        = res_q.status;

endmodule

// ===== rtl/core/rsc_checker.sv =====
// Port-level checks of the core, attached to the top level by a bind.
module rsc_checker
	import rsc_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic                     reg_written,
	input logic [4:0]               written_reg,
	input logic [9:0]               mem_latency,
	input logic [1:0]               row_event,
	input logic                     status,
	input logic                     psel,
	input logic                     penable,
	input logic                     pwrite,
	input logic [APB_ADDR_BITS-1:0] paddr,
	input logic [31:0]              pwdata,
	input logic [31:0]              prdata
);

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result transaction dropped while stalled");

	// A rejected address touches nothing, so it can report no timing and no write.
	a_bad_addr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_BAD_ADDR |->
			mem_latency == 10'd0 && row_event == EV_NONE && !reg_written)
		else $error("bad address result carries side effects");

	a_no_reg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reg_written |-> written_reg != 5'd0)
		else $error("write to register zero reported");

	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $past(psel && penable && pwrite) && $past(paddr[2]) == paddr[2]
			|-> prdata == {24'd0, $past(pwdata[7:0])})
		else $error("configuration register does not read back");

endmodule

bind risc_subset_core_with_dram_row_timing rsc_checker u_rsc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.reg_written (result.reg_written),
	.written_reg (result.written_reg),
	.mem_latency (result.mem_latency),
	.row_event   (result.row_event),
	.status      (result.status),
	.psel        (psel),
	.penable     (penable),
	.pwrite      (pwrite),
	.paddr       (paddr),
	.pwdata      (pwdata),
	.prdata      (prdata)
);
